FILE: rtl/fvp_pkg.sv
// ----------------------------------------------------------------------------
// fvp_pkg
// Shared constants and transaction types for the value-purge FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package fvp_pkg;

   // Store depth and derived widths
   localparam int DEPTH      = 16;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int VALUE_W    = 32;
   localparam int CNT_FIELD_W = 5;

   // Operation codes
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_PURGE  = 1'b1;

   // Status codes
   localparam logic STAT_DONE = 1'b0;
   localparam logic STAT_FULL = 1'b1;

   typedef struct packed {
      logic                       operation;
      logic signed [VALUE_W-1:0]  operand_value;
   } req_type;

   typedef struct packed {
      logic                    status;
      logic [CNT_FIELD_W-1:0]  removed_count;
      logic [CNT_FIELD_W-1:0]  occupancy;
      logic [CNT_FIELD_W-1:0]  even_count;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/fvp_ram.sv
// ----------------------------------------------------------------------------
// fvp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fvp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/fifo_with_value_purge.sv
// ----------------------------------------------------------------------------
// fifo_with_value_purge
// Bounded FIFO of signed 32-bit values with in-place purge of a given value.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_data and raise start; the transaction is taken
//   at a rising edge where start is high and busy is low. operation selects
//   append at tail or purge of every entry equal to operand_value.
//   Response channel: every request returns one response on rsp_data, valid
//   for exactly one cycle while rsp_valid is high. The receiver cannot stall,
//   so no back-pressure exists on this side.
// Timing and throughput:
//   Append: response in the cycle after acceptance, busy stays low, so an
//   append can be taken every cycle (also in the cycle its response shows).
//   Purge: busy while the single RAM read port walks the entries one per
//   cycle and the same RAM's write port compacts the survivors; the
//   response shows as busy drops (on an empty store busy stays low and the
//   response comes in the cycle after acceptance).
// Reset:
//   Synchronous, active high. Clears the fill count, the even count and the
//   sequencer. The entry RAM is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_value_purge (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire fvp_pkg::req_type req_data,
   output logic                 busy,
   output logic                 rsp_valid,
   output fvp_pkg::rsp_type     rsp_data
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_PURGE
   } state_type;

   state_type state_ff, state_in;

   // Occupancy and number of even entries held
   logic [fvp_pkg::CNT_W-1:0]   fill_ff, fill_in;
   logic [fvp_pkg::CNT_W-1:0]   even_ff, even_in;

   // Purge walk: read pointer, compaction pointer, read-data-pending flag
   logic [fvp_pkg::CNT_W-1:0]   rd_ff, rd_in;
   logic [fvp_pkg::CNT_W-1:0]   wr_ff, wr_in;
   logic                        pend_ff, pend_in;
   logic [fvp_pkg::CNT_W-1:0]   removed_ff, removed_in;
   logic [fvp_pkg::VALUE_W-1:0] value_ff, value_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   fvp_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   // RAM ports
   logic                         ram_we;
   logic [fvp_pkg::ADDR_W-1:0]   ram_waddr;
   logic [fvp_pkg::VALUE_W-1:0]  ram_wdata;
   logic [fvp_pkg::VALUE_W-1:0]  ram_rdata;

   logic accept;
   logic full;
   logic match;
   logic [fvp_pkg::CNT_W-1:0] removed_next;

   assign accept = start && (state_ff == ST_IDLE);
   assign full   = (fill_ff == fvp_pkg::CNT_W'(fvp_pkg::DEPTH));
   assign match  = (ram_rdata == value_ff);
   assign removed_next = removed_ff + fvp_pkg::CNT_W'(1);

   fvp_ram #(
      .WIDTH (fvp_pkg::VALUE_W),
      .DEPTH (fvp_pkg::DEPTH),
      .ADDR_W(fvp_pkg::ADDR_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(rd_ff[fvp_pkg::ADDR_W-1:0]),
      .rd_data(ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      even_in      = even_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      pend_in      = 1'b0;
      removed_in   = removed_ff;
      value_in     = value_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = fill_ff[fvp_pkg::ADDR_W-1:0];
      ram_wdata    = req_data.operand_value;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.operation == fvp_pkg::OP_APPEND) begin
                  // Append: write at tail unless full, answer next cycle
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.removed_count = '0;
                  if (full) begin
                     rsp_data_in.status = fvp_pkg::STAT_FULL;
                  end else begin
                     rsp_data_in.status = fvp_pkg::STAT_DONE;
                     ram_we  = 1'b1;
                     fill_in = fill_ff + fvp_pkg::CNT_W'(1);
                     if (!req_data.operand_value[0]) begin
                        even_in = even_ff + fvp_pkg::CNT_W'(1);
                     end
                  end
                  rsp_data_in.occupancy  = fvp_pkg::CNT_FIELD_W'(fill_in);
                  rsp_data_in.even_count = fvp_pkg::CNT_FIELD_W'(even_in);
               end else if (fill_ff == '0) begin
                  // Purge of an empty store: nothing to walk
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.status        = fvp_pkg::STAT_DONE;
                  rsp_data_in.removed_count = '0;
                  rsp_data_in.occupancy     = '0;
                  rsp_data_in.even_count    = '0;
               end else begin
                  state_in   = ST_PURGE;
                  value_in   = req_data.operand_value;
                  rd_in      = '0;
                  wr_in      = '0;
                  removed_in = '0;
               end
            end
         end

         ST_PURGE: begin
            // Issue the next read while entries remain
            if (rd_ff != fill_ff) begin
               rd_in   = rd_ff + fvp_pkg::CNT_W'(1);
               pend_in = 1'b1;
            end
            // Consume the previous read: drop a match, compact a survivor
            ram_waddr = wr_ff[fvp_pkg::ADDR_W-1:0];
            ram_wdata = ram_rdata;
            if (pend_ff) begin
               if (match) begin
                  removed_in = removed_next;
               end else begin
                  ram_we = 1'b1;
                  wr_in  = wr_ff + fvp_pkg::CNT_W'(1);
               end
               if (rd_ff == fill_ff) begin
                  // Last entry consumed: commit and answer
                  state_in = ST_IDLE;
                  fill_in  = wr_in;
                  if (!value_ff[0]) begin
                     even_in = even_ff - removed_in;
                  end
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.status        = fvp_pkg::STAT_DONE;
                  rsp_data_in.removed_count = fvp_pkg::CNT_FIELD_W'(removed_in);
                  rsp_data_in.occupancy     = fvp_pkg::CNT_FIELD_W'(fill_in);
                  rsp_data_in.even_count    = fvp_pkg::CNT_FIELD_W'(even_in);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         even_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         even_ff      <= even_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ff       <= rd_in;
      wr_ff       <= wr_in;
      removed_ff  <= removed_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/fvp_checker.sv
// ----------------------------------------------------------------------------
// fvp_checker
// Port-level checks for the value-purge FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fvp_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire fvp_pkg::req_type req_data,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire fvp_pkg::rsp_type rsp_data
);

   // An accepted transaction either answers next cycle or holds busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted transaction neither answered nor busy");

   // Busy ends only by delivering a response
   a_busy_ends_with_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> (busy || rsp_valid))
      else $error("busy dropped without a response");

   // A response never shows while a purge is still walking
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // A rejected append removes nothing
   a_full_removes_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == fvp_pkg::STAT_FULL)) |->
         (rsp_data.removed_count == '0))
      else $error("rejected append reports removals");

   // A rejected append answers the append that was just taken
   a_full_from_append: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == fvp_pkg::STAT_FULL)) |->
         ($past(start) && !$past(busy) &&
          ($past(req_data.operation) == fvp_pkg::OP_APPEND)))
      else $error("full status without a preceding append");

endmodule

bind fifo_with_value_purge fvp_checker u_fvp_checker (.*);

`default_nettype wire
